### hdl/tkss_pkg.sv
// Shared types and constants for the top-k range spread sum block.
package tkss_pkg;

    localparam int SAMPLE_W = 31;
    localparam int IDX_W    = 12;
    localparam int KEY_W    = SAMPLE_W + 2 * IDX_W;
    localparam int TOTAL_W  = 63;
    localparam int PICK_W   = 11;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_word;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               exhausted;
    } t_out_word;

    typedef enum logic [4:0] {
        S_LOAD,
        S_BLD_CHK,
        S_BLD_WR,
        S_CLR,
        S_JOB_INIT,
        S_PSH_VRD,
        S_PSH_VCHK,
        S_PSH_SPR,
        S_PSH_UP,
        S_PSH_CMP,
        S_POP_CHK,
        S_POP_TAKE,
        S_POP_DN,
        S_POP_CMP,
        S_NB_START,
        S_NB_TRY,
        S_NB_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_BLD_NXL,
        OP_BLD_RD,
        OP_BLD_WR,
        OP_CLR,
        OP_JOB_INIT,
        OP_VSET,
        OP_PSH_KEY,
        OP_PUP_RD,
        OP_PUP_MOVE,
        OP_PUT_KEY,
        OP_EXH,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_DN_RD,
        OP_DN_MOVE,
        OP_NB_START,
        OP_NB_SET,
        OP_NB_INC,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic bld_done;
        logic bld_fit;
        logic clr_last;
        logic vis_hit;
        logic heap_full;
        logic heap_root;
        logic par_ge;
        logic dn_leaf;
        logic dn_stop;
        logic picks_done;
        logic heap_empty;
        logic nb_ok;
        logic nb_last;
    } t_dp_stat;

endpackage

### hdl/top_k_subarray_spread_sum_top.sv
// Top level of the top-k range spread sum block.
//
//   Channel   Signals                              Direction  Word
//   in        i_in_valid / o_in_ready / i_in_word  input      sample, last
//   out       o_out_valid / i_out_ready / o_out_word output   total, exhausted
//   cfg       i_cfg_valid / o_cfg_ready / i_cfg_data input    pick_count
//
// Samples are taken one per cycle until the word marked last. Then the block
// builds the range tables (a check state and a write state per entry), clears
// the visited bitmap (one row per cycle) and runs the heap search, where each
// pop and each push walks the heap one level at a time, with a read state and
// a compare state per level. Reset clears the control state; no memory needs
// a pass after reset. While a result waits in the output register the block
// keeps taking samples of the next array.
module top_k_subarray_spread_sum_top #(
    parameter int MAX_LEN    = 256,
    parameter int LEVELS     = 9,
    parameter int HEAP_DEPTH = 4096,
    parameter int MAX_PICKS  = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tkss_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tkss_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tkss_pkg::PICK_W-1:0] i_cfg_data
);

    logic [tkss_pkg::PICK_W-1:0]  r_pick;
    logic                         r_out_valid;
    tkss_pkg::t_out_word          r_out_word;
    tkss_pkg::t_dp_stat           stat;
    tkss_pkg::t_dp_op             op;
    logic                         emit;
    logic                         out_free;
    logic [tkss_pkg::TOTAL_W-1:0] dp_total;
    logic                         dp_exh;

    // The configuration register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick <= tkss_pkg::PICK_W'(1);
        end else if (i_cfg_valid) begin
            r_pick <= i_cfg_data;
        end
    end

    // The output register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= '{total: dp_total, exhausted: dp_exh};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    tkss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_word.last),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_emit     (emit),
        .o_op       (op)
    );

    tkss_dp #(
        .MAX_LEN    (MAX_LEN),
        .LEVELS     (LEVELS),
        .HEAP_DEPTH (HEAP_DEPTH),
        .MAX_PICKS  (MAX_PICKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_word   (i_in_word),
        .i_pick      (r_pick),
        .o_stat      (stat),
        .o_total     (dp_total),
        .o_exhausted (dp_exh)
    );

endmodule

### hdl/tkss_ctrl.sv
// Sequencer for loading, table build, visited clear and heap search.
module tkss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_free,
    input  tkss_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_emit,
    output tkss_pkg::t_dp_op  o_op
);

    tkss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkss_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tkss_pkg::S_LOAD: begin
                if (i_in_valid && i_in_last) n_state = tkss_pkg::S_BLD_CHK;
            end
            tkss_pkg::S_BLD_CHK: begin
                if (i_stat.bld_done) n_state = tkss_pkg::S_CLR;
                else if (i_stat.bld_fit) n_state = tkss_pkg::S_BLD_WR;
            end
            tkss_pkg::S_BLD_WR:   n_state = tkss_pkg::S_BLD_CHK;
            tkss_pkg::S_CLR: begin
                if (i_stat.clr_last) n_state = tkss_pkg::S_JOB_INIT;
            end
            tkss_pkg::S_JOB_INIT: n_state = tkss_pkg::S_PSH_VRD;
            tkss_pkg::S_PSH_VRD:  n_state = tkss_pkg::S_PSH_VCHK;
            tkss_pkg::S_PSH_VCHK: begin
                if (i_stat.vis_hit || i_stat.heap_full) n_state = tkss_pkg::S_NB_NEXT;
                else n_state = tkss_pkg::S_PSH_SPR;
            end
            tkss_pkg::S_PSH_SPR:  n_state = tkss_pkg::S_PSH_UP;
            tkss_pkg::S_PSH_UP: begin
                if (i_stat.heap_root) n_state = tkss_pkg::S_NB_NEXT;
                else n_state = tkss_pkg::S_PSH_CMP;
            end
            tkss_pkg::S_PSH_CMP: begin
                if (i_stat.par_ge) n_state = tkss_pkg::S_NB_NEXT;
                else n_state = tkss_pkg::S_PSH_UP;
            end
            tkss_pkg::S_POP_CHK: begin
                if (i_stat.picks_done || i_stat.heap_empty) n_state = tkss_pkg::S_DONE;
                else n_state = tkss_pkg::S_POP_TAKE;
            end
            tkss_pkg::S_POP_TAKE: n_state = tkss_pkg::S_POP_DN;
            tkss_pkg::S_POP_DN: begin
                if (i_stat.dn_leaf) n_state = tkss_pkg::S_NB_START;
                else n_state = tkss_pkg::S_POP_CMP;
            end
            tkss_pkg::S_POP_CMP: begin
                if (i_stat.dn_stop) n_state = tkss_pkg::S_NB_START;
                else n_state = tkss_pkg::S_POP_DN;
            end
            tkss_pkg::S_NB_START: n_state = tkss_pkg::S_NB_TRY;
            tkss_pkg::S_NB_TRY: begin
                if (i_stat.nb_ok) n_state = tkss_pkg::S_PSH_VRD;
                else n_state = tkss_pkg::S_NB_NEXT;
            end
            tkss_pkg::S_NB_NEXT: begin
                if (i_stat.nb_last) n_state = tkss_pkg::S_POP_CHK;
                else n_state = tkss_pkg::S_NB_TRY;
            end
            tkss_pkg::S_DONE: begin
                if (i_out_free) n_state = tkss_pkg::S_LOAD;
            end
            default: n_state = tkss_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_op       = tkss_pkg::OP_NONE;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            tkss_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = tkss_pkg::OP_LOAD;
            end
            tkss_pkg::S_BLD_CHK: begin
                if (i_stat.bld_done) o_op = tkss_pkg::OP_NONE;
                else if (i_stat.bld_fit) o_op = tkss_pkg::OP_BLD_RD;
                else o_op = tkss_pkg::OP_BLD_NXL;
            end
            tkss_pkg::S_BLD_WR:   o_op = tkss_pkg::OP_BLD_WR;
            tkss_pkg::S_CLR:      o_op = tkss_pkg::OP_CLR;
            tkss_pkg::S_JOB_INIT: o_op = tkss_pkg::OP_JOB_INIT;
            tkss_pkg::S_PSH_VRD:  o_op = tkss_pkg::OP_NONE;
            tkss_pkg::S_PSH_VCHK: begin
                if (!(i_stat.vis_hit || i_stat.heap_full)) o_op = tkss_pkg::OP_VSET;
            end
            tkss_pkg::S_PSH_SPR:  o_op = tkss_pkg::OP_PSH_KEY;
            tkss_pkg::S_PSH_UP: begin
                if (i_stat.heap_root) o_op = tkss_pkg::OP_PUT_KEY;
                else o_op = tkss_pkg::OP_PUP_RD;
            end
            tkss_pkg::S_PSH_CMP: begin
                if (i_stat.par_ge) o_op = tkss_pkg::OP_PUT_KEY;
                else o_op = tkss_pkg::OP_PUP_MOVE;
            end
            tkss_pkg::S_POP_CHK: begin
                if (i_stat.picks_done) o_op = tkss_pkg::OP_NONE;
                else if (i_stat.heap_empty) o_op = tkss_pkg::OP_EXH;
                else o_op = tkss_pkg::OP_POP_RD;
            end
            tkss_pkg::S_POP_TAKE: o_op = tkss_pkg::OP_POP_TAKE;
            tkss_pkg::S_POP_DN: begin
                if (i_stat.dn_leaf) o_op = tkss_pkg::OP_PUT_KEY;
                else o_op = tkss_pkg::OP_DN_RD;
            end
            tkss_pkg::S_POP_CMP: begin
                if (i_stat.dn_stop) o_op = tkss_pkg::OP_PUT_KEY;
                else o_op = tkss_pkg::OP_DN_MOVE;
            end
            tkss_pkg::S_NB_START: o_op = tkss_pkg::OP_NB_START;
            tkss_pkg::S_NB_TRY: begin
                if (i_stat.nb_ok) o_op = tkss_pkg::OP_NB_SET;
            end
            tkss_pkg::S_NB_NEXT: begin
                if (!i_stat.nb_last) o_op = tkss_pkg::OP_NB_INC;
            end
            tkss_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_op   = tkss_pkg::OP_EMIT;
                    o_emit = 1'b1;
                end
            end
            default: o_op = tkss_pkg::OP_NONE;
        endcase
    end

endmodule

### hdl/tkss_dp.sv
// Datapath: range tables, visited bitmap, range heap and running total.
module tkss_dp #(
    parameter int MAX_LEN    = 256,
    parameter int LEVELS     = 9,
    parameter int HEAP_DEPTH = 4096,
    parameter int MAX_PICKS  = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tkss_pkg::t_dp_op              i_op,
    input  tkss_pkg::t_in_word            i_in_word,
    input  logic [tkss_pkg::PICK_W-1:0]   i_pick,
    output tkss_pkg::t_dp_stat            o_stat,
    output logic [tkss_pkg::TOTAL_W-1:0]  o_total,
    output logic                          o_exhausted
);

    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LCW  = $clog2(LEVELS + 1);
    localparam int SW   = ((CW > LEVELS) ? CW : LEVELS) + 2;
    localparam int HAW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HSW  = $clog2(HEAP_DEPTH + 1);
    localparam int KW   = $clog2(MAX_PICKS + 1);
    localparam int SPW  = tkss_pkg::SAMPLE_W;
    localparam int IXW  = tkss_pkg::IDX_W;
    localparam int KYW  = tkss_pkg::KEY_W;

    typedef struct packed {
        logic [SPW-1:0] mx;
        logic [SPW-1:0] mn;
    } t_ent;

    // Memories.
    t_ent              tbl [LEVELS][MAX_LEN];
    logic [MAX_LEN-1:0] vis [MAX_LEN];
    logic [KYW-1:0]    heap [HEAP_DEPTH];

    // Registers.
    logic [CW-1:0]  r_cnt;
    logic [LCW-1:0] r_lvl;
    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  r_clr;
    logic [AW-1:0]  r_pl, r_pr;
    logic [AW-1:0]  r_cl, r_cr;
    logic [1:0]     r_nb;
    t_ent           r_ta, r_tb;
    logic [MAX_LEN-1:0] r_vrow;
    logic [KYW-1:0] r_hda, r_hdb, r_hkey;
    logic [HAW-1:0] r_hi;
    logic [HSW-1:0] r_hsize;
    logic [KW-1:0]  r_pops;
    logic [tkss_pkg::TOTAL_W-1:0] r_total;
    logic           r_exh;

    // Build addressing.
    logic [LVW-1:0] bld_lvl_rd, bld_lvl_wr;
    logic [SW-1:0]  span, half, bld_end, bld_ib;
    // Query addressing.
    logic [CW:0]    q_len;
    logic [LVW-1:0] q_lvl;
    logic [CW:0]    q_b;
    // Table read mux.
    logic [LVW-1:0] t_lvl;
    logic [AW-1:0]  t_ia, t_ib;
    // Heap addressing.
    logic [HSW:0]   dn_c, dn_c1;
    logic [HAW-1:0] par_i;
    logic [HAW-1:0] h_ra, h_rb;
    logic           dn_sel_b;
    logic [KYW-1:0] dn_child;
    logic [HAW-1:0] dn_child_i;
    // Spread.
    logic [SPW-1:0] sp_hi, sp_lo, spread;
    // Neighbours.
    logic           nb_ok;
    logic [AW-1:0]  nb_l, nb_r;
    logic [KW:0]    k_lim;
    logic [CW:0]    n_ext;

    function automatic logic [LVW-1:0] lvl_of(input logic [CW:0] len);
        logic [LVW-1:0] res;
        res = '0;
        for (int b = 0; b <= CW; b++) begin
            if (len[b]) res = (b > LEVELS - 1) ? LVW'(LEVELS - 1) : LVW'(b);
        end
        return res;
    endfunction

    assign bld_lvl_wr = r_lvl[LVW-1:0];
    assign bld_lvl_rd = LVW'(r_lvl - LCW'(1));
    assign span       = SW'(1) << r_lvl;
    assign half       = SW'(1) << bld_lvl_rd;
    assign bld_end    = SW'(r_idx) + span;
    assign bld_ib     = SW'(r_idx) + half;

    assign q_len = (CW+1)'(r_pr) - (CW+1)'(r_pl) + (CW+1)'(1);
    assign q_lvl = lvl_of(q_len);
    assign q_b   = (CW+1)'(r_pr) + (CW+1)'(1) - ((CW+1)'(1) << q_lvl);

    always_comb begin
        if (i_op == tkss_pkg::OP_BLD_RD) begin
            t_lvl = bld_lvl_rd;
            t_ia  = r_idx;
            t_ib  = bld_ib[AW-1:0];
        end else begin
            t_lvl = q_lvl;
            t_ia  = r_pl;
            t_ib  = q_b[AW-1:0];
        end
    end

    // Sparse table memory: two registered reads, one write.
    always_ff @(posedge i_clk) begin
        r_ta <= tbl[t_lvl][t_ia];
        r_tb <= tbl[t_lvl][t_ib];
        if (i_op == tkss_pkg::OP_LOAD && r_cnt < CW'(MAX_LEN)) begin
            tbl[0][r_cnt[AW-1:0]] <= '{mx: i_in_word.sample, mn: i_in_word.sample};
        end else if (i_op == tkss_pkg::OP_BLD_WR) begin
            tbl[bld_lvl_wr][r_idx] <= '{
                mx: (r_ta.mx > r_tb.mx) ? r_ta.mx : r_tb.mx,
                mn: (r_ta.mn < r_tb.mn) ? r_ta.mn : r_tb.mn};
        end
    end

    // Visited bitmap, one row per left index.
    always_ff @(posedge i_clk) begin
        r_vrow <= vis[r_pl];
        if (i_op == tkss_pkg::OP_CLR) begin
            vis[r_clr] <= '0;
        end else if (i_op == tkss_pkg::OP_VSET) begin
            vis[r_pl] <= r_vrow | (MAX_LEN'(1) << r_pr);
        end
    end

    assign par_i    = HAW'((HSW'(r_hi) - HSW'(1)) >> 1);
    assign dn_c     = ((HSW+1)'(r_hi) << 1) + (HSW+1)'(1);
    assign dn_c1    = dn_c + (HSW+1)'(1);
    assign dn_sel_b = (dn_c1 < (HSW+1)'(r_hsize)) && (r_hdb > r_hda);
    assign dn_child   = dn_sel_b ? r_hdb : r_hda;
    assign dn_child_i = dn_sel_b ? dn_c1[HAW-1:0] : dn_c[HAW-1:0];

    always_comb begin
        h_ra = dn_c[HAW-1:0];
        h_rb = dn_c1[HAW-1:0];
        case (i_op)
            tkss_pkg::OP_PUP_RD: h_ra = par_i;
            tkss_pkg::OP_POP_RD: begin
                h_ra = '0;
                h_rb = HAW'(r_hsize - HSW'(1));
            end
            default: ;
        endcase
    end

    // Range heap memory.
    always_ff @(posedge i_clk) begin
        r_hda <= heap[h_ra];
        r_hdb <= heap[h_rb];
        case (i_op)
            tkss_pkg::OP_PUT_KEY:  heap[r_hi] <= r_hkey;
            tkss_pkg::OP_PUP_MOVE: heap[r_hi] <= r_hda;
            tkss_pkg::OP_DN_MOVE:  heap[r_hi] <= dn_child;
            default: ;
        endcase
    end

    assign sp_hi  = (r_ta.mx > r_tb.mx) ? r_ta.mx : r_tb.mx;
    assign sp_lo  = (r_ta.mn < r_tb.mn) ? r_ta.mn : r_tb.mn;
    assign spread = sp_hi - sp_lo;

    assign n_ext = (CW+1)'(r_cnt);

    always_comb begin
        nb_ok = 1'b0;
        nb_l  = r_cl;
        nb_r  = r_cr;
        case (r_nb)
            2'd0: begin
                nb_ok = (r_cl != '0);
                nb_l  = r_cl - AW'(1);
            end
            2'd1: begin
                nb_ok = (r_cl < r_cr);
                nb_l  = r_cl + AW'(1);
            end
            2'd2: begin
                nb_ok = ((CW+1)'(r_cr) + (CW+1)'(1) < n_ext);
                nb_r  = r_cr + AW'(1);
            end
            default: begin
                nb_ok = (r_cl < r_cr);
                nb_r  = r_cr - AW'(1);
            end
        endcase
    end

    assign k_lim = (32'(i_pick) > 32'(MAX_PICKS)) ? (KW+1)'(MAX_PICKS) : (KW+1)'(i_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_hsize <= '0;
            r_total <= '0;
            r_exh   <= 1'b0;
        end else begin
            case (i_op)
                tkss_pkg::OP_LOAD: begin
                    if (r_cnt < CW'(MAX_LEN)) r_cnt <= r_cnt + CW'(1);
                end
                tkss_pkg::OP_JOB_INIT: begin
                    r_hsize <= '0;
                    r_total <= '0;
                    r_exh   <= 1'b0;
                end
                tkss_pkg::OP_PSH_KEY:  r_hsize <= r_hsize + HSW'(1);
                tkss_pkg::OP_EXH:      r_exh   <= 1'b1;
                tkss_pkg::OP_POP_TAKE: begin
                    r_hsize <= r_hsize - HSW'(1);
                    r_total <= r_total + tkss_pkg::TOTAL_W'(r_hda[KYW-1 -: SPW]);
                end
                tkss_pkg::OP_EMIT:     r_cnt <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            tkss_pkg::OP_LOAD: begin
                r_lvl <= LCW'(1);
                r_idx <= '0;
                r_clr <= '0;
            end
            tkss_pkg::OP_BLD_NXL: begin
                r_lvl <= r_lvl + LCW'(1);
                r_idx <= '0;
            end
            tkss_pkg::OP_BLD_WR:  r_idx <= r_idx + AW'(1);
            tkss_pkg::OP_CLR:     r_clr <= r_clr + AW'(1);
            tkss_pkg::OP_JOB_INIT: begin
                r_pl   <= '0;
                r_pr   <= AW'(r_cnt - CW'(1));
                r_nb   <= 2'd3;
                r_pops <= '0;
            end
            tkss_pkg::OP_PSH_KEY: begin
                r_hkey <= {spread, IXW'(r_pl), IXW'(r_pr)};
                r_hi   <= HAW'(r_hsize);
            end
            tkss_pkg::OP_PUP_MOVE: r_hi <= par_i;
            tkss_pkg::OP_POP_TAKE: begin
                r_cl   <= r_hda[IXW+AW-1:IXW];
                r_cr   <= r_hda[AW-1:0];
                r_hkey <= r_hdb;
                r_hi   <= '0;
                r_pops <= r_pops + KW'(1);
            end
            tkss_pkg::OP_DN_MOVE: r_hi <= dn_child_i;
            tkss_pkg::OP_NB_START: r_nb <= 2'd0;
            tkss_pkg::OP_NB_SET: begin
                r_pl <= nb_l;
                r_pr <= nb_r;
            end
            tkss_pkg::OP_NB_INC: r_nb <= r_nb + 2'd1;
            default: ;
        endcase
    end

    assign o_stat.bld_done   = (r_lvl >= LCW'(LEVELS));
    assign o_stat.bld_fit    = (bld_end <= SW'(r_cnt));
    assign o_stat.clr_last   = (r_clr == AW'(MAX_LEN - 1));
    assign o_stat.vis_hit    = r_vrow[r_pr];
    assign o_stat.heap_full  = (r_hsize >= HSW'(HEAP_DEPTH));
    assign o_stat.heap_root  = (r_hi == '0);
    assign o_stat.par_ge     = (r_hda >= r_hkey);
    assign o_stat.dn_leaf    = (dn_c >= (HSW+1)'(r_hsize));
    assign o_stat.dn_stop    = (dn_child <= r_hkey);
    assign o_stat.picks_done = ((KW+1)'(r_pops) >= k_lim);
    assign o_stat.heap_empty = (r_hsize == '0);
    assign o_stat.nb_ok      = nb_ok;
    assign o_stat.nb_last    = (r_nb == 2'd3);

    assign o_total     = r_total;
    assign o_exhausted = r_exh;

endmodule

### tb/sv/top_k_subarray_spread_sum_top_tb.sv
// Self-checking testbench for the top-k range spread sum block.
`timescale 1ns / 1ps

module top_k_subarray_spread_sum_top_tb;
    import tkss_pkg::*;

    localparam int ARR_MAX    = 256;
    localparam int TBL_LEVELS = 9;
    localparam int HEAP_CAP   = 4096;
    localparam int PICK_CAP   = 1024;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // The scoreboard keeps its own copy of the array and of the pick count, and
    // replays the search whenever a word marked last is accepted.
    class spread_scoreboard;
        logic [SAMPLE_W-1:0] arr [ARR_MAX];
        int unsigned         arr_len;
        logic [PICK_W-1:0]   picks;
        t_out_word           sums_due [$];
        logic [SAMPLE_W-1:0] hi_tbl [TBL_LEVELS][ARR_MAX];
        logic [SAMPLE_W-1:0] lo_tbl [TBL_LEVELS][ARR_MAX];
        logic [KEY_W-1:0]    heap [HEAP_CAP];
        int unsigned         heap_len;
        bit                  seen [ARR_MAX*ARR_MAX];
        int                  errors;
        int                  words_in;
        int                  sums_out;
        int                  exhausted_seen;

        function new();
            arr_len = 0;
            picks = 1;
            errors = 0;
            words_in = 0;
            sums_out = 0;
            exhausted_seen = 0;
        endfunction

        function void set_picks(logic [PICK_W-1:0] v);
            picks = v;
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        function logic [SAMPLE_W-1:0] spread(int unsigned l, int unsigned r);
            int unsigned lvl, b, w;
            logic [SAMPLE_W-1:0] hi, lo;
            lvl = 0;
            w = r - l + 1;
            while (w > 1) begin
                w = w >> 1;
                lvl++;
            end
            if (lvl > TBL_LEVELS - 1) lvl = TBL_LEVELS - 1;
            b = r + 1 - (1 << lvl);
            hi = (hi_tbl[lvl][l] > hi_tbl[lvl][b]) ? hi_tbl[lvl][l] : hi_tbl[lvl][b];
            lo = (lo_tbl[lvl][l] < lo_tbl[lvl][b]) ? lo_tbl[lvl][l] : lo_tbl[lvl][b];
            return hi - lo;
        endfunction

        function void push_range(int unsigned l, int unsigned r);
            logic [KEY_W-1:0] key;
            int unsigned i, p;
            if (seen[l*ARR_MAX + r] || heap_len >= HEAP_CAP) return;
            seen[l*ARR_MAX + r] = 1;
            key = {spread(l, r), l[IDX_W-1:0], r[IDX_W-1:0]};
            i = heap_len;
            heap_len++;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (heap[p] >= key) break;
                heap[i] = heap[p];
                i = p;
            end
            heap[i] = key;
        endfunction

        function logic [KEY_W-1:0] pop_range();
            logic [KEY_W-1:0] top, t;
            int unsigned i, c;
            top = heap[0];
            heap_len--;
            heap[0] = heap[heap_len];
            i = 0;
            forever begin
                c = 2 * i + 1;
                if (c >= heap_len) break;
                if (c + 1 < heap_len && heap[c+1] > heap[c]) c++;
                if (heap[c] <= heap[i]) break;
                t = heap[c];
                heap[c] = heap[i];
                heap[i] = t;
                i = c;
            end
            return top;
        endfunction

        // Runs the best-first search over the collected array and queues the sum.
        function void predict_sum();
            int unsigned n, k, l, r, span, half;
            logic [63:0] acc;
            logic [KEY_W-1:0] key;
            t_out_word res;
            n = arr_len;
            for (int unsigned i = 0; i < n; i++) begin
                hi_tbl[0][i] = arr[i];
                lo_tbl[0][i] = arr[i];
            end
            for (int unsigned j = 1; j < TBL_LEVELS; j++) begin
                half = 1 << (j - 1);
                span = 1 << j;
                for (int unsigned i = 0; i + span <= n; i++) begin
                    hi_tbl[j][i] = (hi_tbl[j-1][i] > hi_tbl[j-1][i+half]) ?
                                   hi_tbl[j-1][i] : hi_tbl[j-1][i+half];
                    lo_tbl[j][i] = (lo_tbl[j-1][i] < lo_tbl[j-1][i+half]) ?
                                   lo_tbl[j-1][i] : lo_tbl[j-1][i+half];
                end
            end
            foreach (seen[i]) seen[i] = 0;
            heap_len = 0;
            acc = 0;
            res.exhausted = 0;
            push_range(0, n - 1);
            k = (picks > PICK_CAP) ? PICK_CAP : picks;
            for (int unsigned p = 0; p < k; p++) begin
                if (heap_len == 0) begin
                    res.exhausted = 1;
                    break;
                end
                key = pop_range();
                acc += key[KEY_W-1:2*IDX_W];
                l = key[2*IDX_W-1:IDX_W];
                r = key[IDX_W-1:0];
                if (l > 0) push_range(l - 1, r);
                if (l + 1 <= r) push_range(l + 1, r);
                if (r + 1 < n) push_range(l, r + 1);
                if (r >= l + 1) push_range(l, r - 1);
            end
            res.total = acc[TOTAL_W-1:0];
            sums_due.push_back(res);
        endfunction

        function void note_word(t_in_word w);
            words_in++;
            if (arr_len < ARR_MAX) begin
                arr[arr_len] = w.sample;
                arr_len++;
            end
            if (w.last) begin
                predict_sum();
                arr_len = 0;
            end
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_sum(t_out_word got);
            t_out_word want;
            sums_out++;
            if (sums_due.size() == 0) begin
                report($sformatf("unexpected result total=%0d exhausted=%0b",
                                 got.total, got.exhausted));
                return;
            end
            want = sums_due.pop_front();
            if (want.exhausted) exhausted_seen++;
            if (got.total !== want.total)
                report($sformatf("total got %0d want %0d", got.total, want.total));
            if (got.exhausted !== want.exhausted)
                report($sformatf("exhausted got %0b want %0b",
                                 got.exhausted, want.exhausted));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [PICK_W-1:0] i_cfg_data;

    spread_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int arrays_sent;

    top_k_subarray_spread_sum_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: every word taken is checked against the oldest predicted sum.
    // Ready is redrawn once per cycle, whatever phase the search is in.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_sum(o_out_word);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one word and holds it until the block takes it. Valid is left high
    // afterwards so that back-to-back words need no bubble; an idle gap lowers it.
    task send_word(logic [SAMPLE_W-1:0] s, logic l);
        t_in_word w;
        w.sample = s;
        w.last = l;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    // Lowers valid and waits until every predicted sum has been taken, then lets
    // the block settle so a register write cannot land in the middle of a job.
    task drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_picks(logic [PICK_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_picks(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Draws one sample in the given style: full range, a narrow band that makes
    // many equal spreads, a single repeated value, or only the two extremes.
    function logic [SAMPLE_W-1:0] draw_sample(int style, logic [SAMPLE_W-1:0] base);
        case (style)
            0: return SAMPLE_W'($urandom());
            1: return base + SAMPLE_W'($urandom_range(3));
            2: return base;
            default: return $urandom_range(1) ? SAMPLE_MAX : '0;
        endcase
    endfunction

    task send_array(int len);
        int style;
        logic [SAMPLE_W-1:0] base;
        style = $urandom_range(3);
        base = SAMPLE_W'($urandom()) >> 1;
        for (int i = 0; i < len; i++)
            send_word(draw_sample(style, base), i == len - 1);
        arrays_sent++;
    endtask

    task send_values(logic [SAMPLE_W-1:0] vals [$]);
        foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
        arrays_sent++;
    endtask

    initial begin
        logic [PICK_W-1:0] phase_picks [8];
        int len;
        sb = new();
        cycle_count = 0;
        arrays_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset pick count of one: a single element, the
        // two sample extremes, a flat array, and a short array with ties.
        send_values('{SAMPLE_MAX});
        send_values('{'0, SAMPLE_MAX});
        send_values('{SAMPLE_MAX, '0, SAMPLE_MAX});
        send_values('{31'd7, 31'd7, 31'd7});
        drain_block();
        // Zero picks gives a zero total; more picks than ranges runs the queue dry;
        // an all-ones register saturates to the pick limit.
        write_picks('0);
        send_values('{31'd5, 31'd9});
        drain_block();
        write_picks(11'd6);
        send_values('{31'd1, 31'd4, 31'd2});
        send_values('{31'd3, 31'd3});
        drain_block();
        write_picks('1);
        send_values('{31'd10, '0, 31'd3, SAMPLE_MAX});
        drain_block();

        // Random phases. Each one sets the idling mix and a new pick count, with
        // the block drained before the write; the draining also makes the sender
        // wait out every outstanding result.
        phase_picks = '{11'd1, 11'd0, 11'd37, 11'd2047, 11'd1024,
                        11'($urandom_range(1, 300)), 11'd5, 11'($urandom_range(1, 2047))};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_picks(phase_picks[ph]);
            // One full-length array at the pick limit, and one that runs past
            // the array capacity so its tail is dropped.
            if (ph == 4) send_array(ARR_MAX);
            if (ph == 5) send_array(ARR_MAX + $urandom_range(1, 9));
            while (sb.words_in < 60 + 150 * (ph + 1)) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
                send_array(len);
            end
            drain_block();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d words in %0d arrays, %0d results checked, %0d runs dry",
                 sb.words_in, arrays_sent, sb.sums_out, sb.exhausted_seen);
        $display("idling mixes: none, sender, receiver, both; %0d mismatches", sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
